@@ src/slsa_pkg.sv @@
// Shared types, constants and table helpers for the sunlit/shaded area split.
// No dependencies; used by slsa_sun_lane and sunlit_shaded_leaf_area_split.
package slsa_pkg;

    localparam int AREA_W    = 16;
    localparam int OUT_W     = 17;
    localparam int CLUMP_W   = 15;
    localparam logic [OUT_W-1:0] AREA_MAX = 17'd131071;
    localparam logic [CLUMP_W-1:0] CLUMP_RESET = 15'd16384;

    // One input request
    typedef struct packed {
        logic signed [15:0]  cos_zenith;
        logic [AREA_W-1:0]   overstory_leaf;
        logic [AREA_W-1:0]   overstory_stem;
        logic [AREA_W-1:0]   understory_leaf;
        logic [AREA_W-1:0]   understory_stem;
    } in_item_t;

    // One result
    typedef struct packed {
        logic [OUT_W-1:0] over_sunlit_plant;
        logic [OUT_W-1:0] over_shaded_plant;
        logic [OUT_W-1:0] under_sunlit_plant;
        logic [OUT_W-1:0] under_shaded_plant;
        logic [OUT_W-1:0] over_sunlit_leaf;
        logic [OUT_W-1:0] over_shaded_leaf;
        logic [OUT_W-1:0] under_sunlit_leaf;
        logic [OUT_W-1:0] under_shaded_leaf;
    } out_item_t;

    // Load enables for the lane's pipeline stages
    typedef struct packed {
        logic st4;
        logic st5;
        logic st6;
        logic st7;
        logic st8;
    } lane_en_t;

    // exp(h) in Q30, h in Q30 (Taylor series, 21 terms)
    function automatic logic [63:0] exp_sum(input logic [63:0] h);
        logic [63:0] term;
        logic [63:0] acc;
        term = 64'd1 << 30;
        acc  = 64'd1 << 30;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * h) >> 30) / 64'(k);
            acc  = acc + term;
        end
        return acc;
    endfunction

    // Table entry k: g^k in Q30 rounded to Q16
    function automatic logic [16:0] exp_entry(input logic [63:0] g, input int k);
        logic [63:0] e;
        e = 64'd1 << 30;
        for (int i = 1; i <= k; i++)
        begin
            e = (e * g + (64'd1 << 29)) >> 30;
        end
        return 17'((e + (64'd1 << 13)) >> 14);
    endfunction

    // Clamp a signed area to the result range
    function automatic logic [OUT_W-1:0] sat_area(input logic signed [19:0] v);
        logic [OUT_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v > 20'sd131071)
        begin
            res = AREA_MAX;
        end
        else
        begin
            res = v[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ src/slsa_sun_lane.sv @@
// One sunlit-area lane: exponent argument, exp table interpolation, 2c(1-e).
// Depends on slsa_pkg; instantiated four times by the top level.
module slsa_sun_lane #(
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic              clk,
    input  slsa_pkg::lane_en_t en,
    input  logic [32:0]       cl_area,
    input  logic [16:0]       recip,
    input  logic [3:0]        shift,
    input  logic [14:0]       cosz,
    output logic [15:0]       sunlit
);

    localparam int EW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [63:0] EXP_H = (64'd1 << 34) / EXP_TABLE_DEPTH;
    localparam logic [63:0] EXP_A = slsa_pkg::exp_sum(EXP_H);
    // exp(-h) step ratio in Q30
    localparam logic [63:0] EXP_G = ((64'd1 << 60) + (EXP_A >> 1)) / EXP_A;

    // exp(-16k/depth) in Q16
    logic [16:0] exp_rom [0:EXP_TABLE_DEPTH];
    for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++)
    begin : g_rom
        localparam logic [16:0] TV = slsa_pkg::exp_entry(EXP_G, k);
        assign exp_rom[k] = TV;
    end

    logic [49:0]   t_reg;
    logic [3:0]    s4_reg;
    logic [14:0]   c4_reg, c5_reg, c6_reg, c7_reg;
    logic          big5_reg, big6_reg;
    logic [EW-1:0] idx5_reg;
    logic [19:0]   rem5_reg, rem6_reg;
    logic [16:0]   a6_reg, d6_reg, e7_reg;
    logic [15:0]   sun8_reg;

    logic [63:0]      shifted;
    logic [36:0]      xval;
    logic [20+EW-1:0] xprod;
    logic [16:0]      ta, tb;
    logic [36:0]      dprod;
    logic [16:0]      e_next;
    logic [16:0]      om;
    logic [32:0]      sprod;

    // Stage 5: exponent argument in Q16 and table position
    assign shifted = {14'd0, t_reg} << s4_reg;
    assign xval    = shifted[63:27];
    assign xprod   = {EW'(0), xval[19:0]} * (20+EW)'(EXP_TABLE_DEPTH);

    // Stage 6: table pair
    assign ta = exp_rom[idx5_reg];
    assign tb = exp_rom[EW'(idx5_reg + EW'(1))];

    // Stage 7: interpolation
    assign dprod  = {20'd0, d6_reg} * {17'd0, rem6_reg};
    assign e_next = big6_reg ? 17'd0 : a6_reg - 17'(dprod >> 20);

    // Stage 8: 2c(1 - e), rounded
    assign om    = 17'd65536 - e7_reg;
    assign sprod = 33'({17'd0, c7_reg} * {15'd0, om}) + 33'd65536;

    always_ff @(posedge clk)
    begin
        if (en.st4)
        begin
            t_reg  <= 50'({17'd0, cl_area} * {33'd0, recip});
            s4_reg <= shift;
            c4_reg <= cosz;
        end
        if (en.st5)
        begin
            big5_reg <= |xval[36:20];
            idx5_reg <= xprod[20+EW-1:20];
            rem5_reg <= xprod[19:0];
            c5_reg   <= c4_reg;
        end
        if (en.st6)
        begin
            a6_reg   <= ta;
            d6_reg   <= ta - tb;
            rem6_reg <= rem5_reg;
            big6_reg <= big5_reg;
            c6_reg   <= c5_reg;
        end
        if (en.st7)
        begin
            e7_reg <= e_next;
            c7_reg <= c6_reg;
        end
        if (en.st8)
        begin
            sun8_reg <= sprod[32:17];
        end
    end

    assign sunlit = sun8_reg;

endmodule

@@ src/sunlit_shaded_leaf_area_split.sv @@
// Top level of the two-leaf sunlit/shaded canopy area split.
// Depends on slsa_pkg and slsa_sun_lane.
//
// Takes one request per cycle while the output is not stalled and returns one
// result per request, in order, nine register stages after acceptance: input
// register, normalization, reciprocal lookup, exponent product, table position,
// table read, interpolation, sunlit product, and the saturating output register.
// Each stage holds its own valid bit, so bubbles close up while the output waits.
// The clumping index is written through the cfg port, which is always ready;
// write it only while no request is in flight.
module sunlit_shaded_leaf_area_split #(
    parameter int EXP_TABLE_DEPTH   = 256,
    parameter int RECIP_TABLE_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  slsa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output slsa_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [14:0]         cfg_data
);

    localparam int NSTG = 9;
    localparam int RW   = $clog2(RECIP_TABLE_DEPTH + 1);

    typedef struct packed {
        logic [15:0] ol;
        logic [15:0] ul;
        logic [16:0] po;
        logic [16:0] pu;
    } layer_t;

    // 1/m in Q16 for m = 1 + k/depth
    logic [16:0] recip_rom [0:RECIP_TABLE_DEPTH];
    for (genvar k = 0; k <= RECIP_TABLE_DEPTH; k++)
    begin : g_rrom
        localparam logic [16:0] RV = 17'(((64'd1 << 17) * RECIP_TABLE_DEPTH
            + RECIP_TABLE_DEPTH + k) / (2 * (RECIP_TABLE_DEPTH + k)));
        assign recip_rom[k] = RV;
    end

    logic [14:0]         clump_reg;
    logic [NSTG:1]       valid_reg, valid_next, rdy;
    slsa_pkg::in_item_t  in_reg;
    logic [14:0]         c2_reg, c3_reg;
    logic [3:0]          s2_reg, s3_reg;
    logic [RW-1:0]       ridx2_reg;
    logic [13:0]         rrem2_reg;
    logic [17:0]         area2_reg [4];
    logic [32:0]         cl3_reg [4];
    logic [16:0]         r3_reg;
    layer_t              lay_reg [2:8];
    slsa_pkg::out_item_t out_reg;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clump_reg <= slsa_pkg::CLUMP_RESET;
        end
        else if (cfg_valid)
        begin
            clump_reg <= cfg_data;
        end
    end

    // Stage handshake: a stage loads when empty or when its successor loads
    always_comb
    begin
        rdy[NSTG] = !valid_reg[NSTG] || out_ready;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end
    assign valid_next = (valid_reg & ~rdy) | ({valid_reg[NSTG-1:1], in_valid} & rdy);
    assign in_ready   = rdy[1];
    assign out_valid  = valid_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 2: day test, normalization shift, reciprocal table position
    logic        day;
    logic [14:0] cpos;
    logic [3:0]  s_next;
    logic [14:0] n_norm;
    logic [13+RW:0] fprod;
    assign day  = (in_reg.cos_zenith != 16'sd0) && !in_reg.cos_zenith[15];
    assign cpos = day ? in_reg.cos_zenith[14:0] : 15'd0;

    always_comb
    begin
        s_next = 4'd0;
        for (int b = 0; b < 15; b++)
        begin
            if (cpos[b])
            begin
                s_next = 4'(14 - b);
            end
        end
    end
    assign n_norm = cpos << s_next;
    assign fprod  = {RW'(0), n_norm[13:0]} * (14+RW)'(RECIP_TABLE_DEPTH);

    // Stage 3: reciprocal interpolation
    logic [16:0] ra, rb, rdiff;
    logic [30:0] rprod;
    assign ra    = recip_rom[ridx2_reg];
    assign rb    = recip_rom[RW'(ridx2_reg + RW'(1))];
    assign rdiff = ra - rb;
    assign rprod = {14'd0, rdiff} * {17'd0, rrem2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            in_reg <= in_data;
        end
        if (rdy[2])
        begin
            c2_reg       <= cpos;
            s2_reg       <= s_next;
            ridx2_reg    <= fprod[13+RW:14];
            rrem2_reg    <= fprod[13:0];
            area2_reg[0] <= 18'(in_reg.overstory_leaf) + 18'(in_reg.overstory_stem);
            area2_reg[1] <= 18'(in_reg.overstory_leaf) + 18'(in_reg.overstory_stem)
                          + 18'(in_reg.understory_leaf) + 18'(in_reg.understory_stem);
            area2_reg[2] <= 18'(in_reg.overstory_leaf);
            area2_reg[3] <= 18'(in_reg.overstory_leaf) + 18'(in_reg.understory_leaf);
            lay_reg[2].ol <= in_reg.overstory_leaf;
            lay_reg[2].ul <= in_reg.understory_leaf;
            lay_reg[2].po <= 17'(in_reg.overstory_leaf) + 17'(in_reg.overstory_stem);
            lay_reg[2].pu <= 17'(in_reg.understory_leaf) + 17'(in_reg.understory_stem);
        end
        if (rdy[3])
        begin
            r3_reg <= ra - 17'(rprod >> 14);
            c3_reg <= c2_reg;
            s3_reg <= s2_reg;
            for (int ln = 0; ln < 4; ln++)
            begin
                cl3_reg[ln] <= {18'd0, clump_reg} * {15'd0, area2_reg[ln]};
            end
        end
        for (int k = 3; k <= 8; k++)
        begin
            if (rdy[k])
            begin
                lay_reg[k] <= lay_reg[k-1];
            end
        end
    end

    // Stages 4 to 8: four sunlit lanes
    slsa_pkg::lane_en_t lane_en;
    logic [15:0] sun [4];
    assign lane_en = '{st4: rdy[4], st5: rdy[5], st6: rdy[6], st7: rdy[7], st8: rdy[8]};

    for (genvar ln = 0; ln < 4; ln++)
    begin : g_lane
        slsa_sun_lane #(
            .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
        ) u_lane (
            .clk     (clk),
            .en      (lane_en),
            .cl_area (cl3_reg[ln]),
            .recip   (r3_reg),
            .shift   (s3_reg),
            .cosz    (c3_reg),
            .sunlit  (sun[ln])
        );
    end

    // Stage 9: understory differences, shaded parts, saturation
    logic signed [19:0] po_s, pa_s, lo_s, la_s, pu_s, lu_s;
    assign po_s = signed'(20'(sun[0]));
    assign pa_s = signed'(20'(sun[1]));
    assign lo_s = signed'(20'(sun[2]));
    assign la_s = signed'(20'(sun[3]));
    assign pu_s = pa_s - po_s;
    assign lu_s = la_s - lo_s;

    always_ff @(posedge clk)
    begin
        if (rdy[NSTG])
        begin
            out_reg.over_sunlit_plant  <= slsa_pkg::sat_area(po_s);
            out_reg.over_shaded_plant  <= slsa_pkg::sat_area(
                signed'(20'(lay_reg[8].po)) - po_s);
            out_reg.under_sunlit_plant <= slsa_pkg::sat_area(pu_s);
            out_reg.under_shaded_plant <= slsa_pkg::sat_area(
                signed'(20'(lay_reg[8].pu)) - pu_s);
            out_reg.over_sunlit_leaf   <= slsa_pkg::sat_area(lo_s);
            out_reg.over_shaded_leaf   <= slsa_pkg::sat_area(
                signed'(20'(lay_reg[8].ol)) - lo_s);
            out_reg.under_sunlit_leaf  <= slsa_pkg::sat_area(lu_s);
            out_reg.under_shaded_leaf  <= slsa_pkg::sat_area(
                signed'(20'(lay_reg[8].ul)) - lu_s);
        end
    end
    assign out_data = out_reg;

`ifndef SYNTHESIS
    // Empty output stage means the whole pipe can move
    a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NSTG] |-> in_ready)
        else $error("input stalled with empty output stage");

    // A stalled stage keeps its request
    a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[4] && !rdy[4]) |=> valid_reg[4])
        else $error("request dropped in stage 4");

    // Sunlit area grows with area: plant covers leaf
    a_sunlit_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.over_sunlit_plant >= out_data.over_sunlit_leaf))
        else $error("sunlit plant area below sunlit leaf area");
`endif

endmodule
